>>> hdl/fcc_pkg.sv
`default_nettype none

package fcc_pkg;

  // request kinds
  localparam logic KIND_REF = 1'b0;
  localparam logic KIND_SIG = 1'b1;

  // controls broadcast from the sequencer to every cell of the chain
  typedef struct packed {
    logic sig_shift;  // advance the signal delay line
    logic sig_zero;   // head of the delay line takes zero (tail flush)
    logic sig_clear;  // wipe the delay line, wins over sig_shift
    logic ref_shift;  // push a reference sample into the reversed chain
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> hdl/fcc_cell.sv
`default_nettype none

module fcc_cell #(
  parameter int SW = 16,
  parameter int CW = 37
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire fcc_pkg::cell_ctl_t ctl,
  input  wire                     active,
  input  wire  signed [SW-1:0]    sig_in,
  output logic signed [SW-1:0]    sig_out,
  input  wire  signed [SW-1:0]    ref_in,
  output logic signed [SW-1:0]    ref_out,
  input  wire  signed [CW-1:0]    sum_in,
  output logic signed [CW-1:0]    sum_out
);

  logic signed [SW-1:0]   d;
  logic signed [SW-1:0]   r;
  logic signed [2*SW-1:0] prod;
  logic signed [CW-1:0]   p;
  logic signed [CW-1:0]   s;

  assign prod = d * r;

  always_ff @(posedge clk) begin
    if (rst) begin
      d <= '0;
    end else if (ctl.sig_clear) begin
      d <= '0;
    end else if (ctl.sig_shift) begin
      d <= sig_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ref_shift) begin
      r <= ref_in;
    end
    // cells beyond the reference length contribute nothing
    p <= active ? {{(CW-2*SW){prod[2*SW-1]}}, prod} : '0;
    s <= sum_in + p;
  end

  assign sig_out = d;
  assign ref_out = r;
  assign sum_out = s;

endmodule

`default_nettype wire

>>> hdl/fcc_ctrl.sv
`default_nettype none

module fcc_ctrl #(
  parameter int MAX_LEN = 32,
  parameter int CW      = 37,
  parameter int CNT_W   = 6
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire                      kind,
  input  wire                      last,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic signed [CW-1:0]     correlation,
  output logic                     final_res,
  input  wire  signed [CW-1:0]     sum_tail,
  output fcc_pkg::cell_ctl_t       ctl,
  output logic [CNT_W-1:0]         count
);

  localparam int WAIT_CYC = MAX_LEN + 1;
  localparam int WAIT_W   = $clog2(MAX_LEN + 2);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [WAIT_W-1:0] wait_cnt, wait_cnt_next;
  logic [CNT_W-1:0]  flush_left, flush_left_next;
  logic              last_flag, last_flag_next;
  logic [CNT_W-1:0]  count_next;
  logic              closed, closed_next;
  logic              in_acc;
  logic              out_free;
  logic              emit;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next      = state;
    wait_cnt_next   = wait_cnt;
    flush_left_next = flush_left;
    last_flag_next  = last_flag;
    count_next      = count;
    closed_next     = closed;
    ctl             = '0;
    emit            = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind == fcc_pkg::KIND_REF) begin
            if (closed) begin
              count_next    = CNT_W'(1);
              ctl.ref_shift = 1'b1;
            end else if (count < CNT_W'(MAX_LEN)) begin
              count_next    = count + CNT_W'(1);
              ctl.ref_shift = 1'b1;
            end
            closed_next = last;
          end else begin
            ctl.sig_shift = 1'b1;
            if (count == '0) begin
              ctl.sig_clear = last;
            end else begin
              state_next      = ST_BUSY;
              wait_cnt_next   = WAIT_W'(WAIT_CYC);
              flush_left_next = last ? count - CNT_W'(1) : '0;
              last_flag_next  = last;
            end
          end
        end
      end
      ST_BUSY: begin
        if (wait_cnt != '0) begin
          wait_cnt_next = wait_cnt - WAIT_W'(1);
        end else if (out_free) begin
          emit = 1'b1;
          if (flush_left != '0) begin
            ctl.sig_shift   = 1'b1;
            ctl.sig_zero    = 1'b1;
            flush_left_next = flush_left - CNT_W'(1);
            wait_cnt_next   = WAIT_W'(WAIT_CYC);
          end else begin
            ctl.sig_clear = last_flag;
            state_next    = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      closed    <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      closed <= closed_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wait_cnt   <= wait_cnt_next;
    flush_left <= flush_left_next;
    last_flag  <= last_flag_next;
    if (emit) begin
      correlation <= sum_tail;
      final_res   <= last_flag && (flush_left == '0);
    end
  end

endmodule

`default_nettype wire

>>> hdl/full_cross_correlator_unit.sv
// channel   | handshake              | payload
// ----------+------------------------+------------------------------
// input     | in_valid / in_stall    | kind, sample, last
// output    | out_valid / out_stall  | correlation, final_res
//
// A reference request is taken without holding the input. A signal request
// holds the input until each result it causes has been emitted; the partial
// sum ripples one cell per cycle down the chain before each result is taken.
// A result waiting in the output register stalls the next result.
// Reset (synchronous) empties the reference and zeros the signal delay line.
`default_nettype none

module full_cross_correlator_unit #(
  parameter int MAX_LEN      = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              kind,
  input  wire  signed [SAMPLE_WIDTH-1:0]   sample,
  input  wire                              last,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic signed [2*SAMPLE_WIDTH+$clog2(MAX_LEN)-1:0] correlation,
  output logic                             final_res
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int CW    = 2*SAMPLE_WIDTH + $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  fcc_pkg::cell_ctl_t   ctl;
  logic [CNT_W-1:0]     count;
  logic signed [SW-1:0] sig_chain [MAX_LEN+1];
  logic signed [SW-1:0] ref_chain [MAX_LEN+1];
  logic signed [CW-1:0] sum_chain [MAX_LEN+1];

  assign sig_chain[0] = ctl.sig_zero ? '0 : sample;
  assign ref_chain[0] = sample;
  assign sum_chain[0] = '0;

  fcc_ctrl #(
    .MAX_LEN (MAX_LEN),
    .CW      (CW),
    .CNT_W   (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .last        (last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .correlation (correlation),
    .final_res   (final_res),
    .sum_tail    (sum_chain[MAX_LEN]),
    .ctl         (ctl),
    .count       (count)
  );

  // cell j holds signal delay[j] and reference sample ref[count-1-j]
  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    logic active;
    assign active = (count > CNT_W'(j));

    fcc_cell #(
      .SW (SW),
      .CW (CW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .active  (active),
      .sig_in  (sig_chain[j]),
      .sig_out (sig_chain[j+1]),
      .ref_in  (ref_chain[j]),
      .ref_out (ref_chain[j+1]),
      .sum_in  (sum_chain[j]),
      .sum_out (sum_chain[j+1])
    );
  end

endmodule

`default_nettype wire

>>> dv/tb_full_cross_correlator_unit.sv
`timescale 1ns / 100ps

module tb_full_cross_correlator_unit;

  localparam int MAX_LEN     = 32;
  localparam int SW          = 16;
  localparam int CORR_W      = 2*SW + $clog2(MAX_LEN);
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 6000;

  typedef struct {
    logic                 kind;
    logic signed [SW-1:0] sample;
    logic                 last;
  } req_t;

  typedef struct {
    logic signed [CORR_W-1:0] corr;
    logic                     fin;
  } lag_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic signed [SW-1:0] sample = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CORR_W-1:0] correlation;
  logic final_res;

  full_cross_correlator_unit #(
    .MAX_LEN(MAX_LEN),
    .SAMPLE_WIDTH(SW)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .sample(sample),
    .last(last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .correlation(correlation),
    .final_res(final_res)
  );

  always #5 clk = ~clk;

  req_t request_q[$];
  lag_t lag_expected_q[$];
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   n_errors = 0;
  bit   hold_arm = 1'b0;
  bit   hold_seen = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  // correlator state as seen by the checker
  int taps[MAX_LEN];
  int taps_len = 0;
  bit taps_closed = 1'b1;
  int delay_line[MAX_LEN];

  initial foreach (delay_line[j]) delay_line[j] = 0;

  function automatic void shift_delay(int x);
    for (int j = MAX_LEN-1; j > 0; j--) delay_line[j] = delay_line[j-1];
    delay_line[0] = x;
  endfunction

  function automatic logic signed [CORR_W-1:0] tap_dot();
    longint acc;
    acc = 0;
    for (int j = 0; j < taps_len; j++)
      acc += longint'(delay_line[j]) * longint'(taps[taps_len-1-j]);
    return acc[CORR_W-1:0];
  endfunction

  function automatic void predict_lags(req_t r);
    lag_t e;
    if (r.kind == fcc_pkg::KIND_REF) begin
      if (taps_closed) begin
        taps_len = 0;
        taps_closed = 1'b0;
      end
      if (taps_len < MAX_LEN) begin
        taps[taps_len] = int'(r.sample);
        taps_len++;
      end
      if (r.last) taps_closed = 1'b1;
      return;
    end
    shift_delay(int'(r.sample));
    if (taps_len > 0) begin
      e.corr = tap_dot();
      e.fin  = r.last && (taps_len == 1);
      lag_expected_q.push_back(e);
    end
    if (r.last) begin
      // tail flush: zeros pushed in, one lag per shift
      for (int k = 1; k < taps_len; k++) begin
        shift_delay(0);
        e.corr = tap_dot();
        e.fin  = (k == taps_len - 1);
        lag_expected_q.push_back(e);
      end
      foreach (delay_line[j]) delay_line[j] = 0;
    end
  endfunction

  always @(posedge clk) begin : drive_requests
    req_t nxt;
    req_t cur;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        cur.kind   = kind;
        cur.sample = sample;
        cur.last   = last;
        predict_lags(cur);
      end
      if (!in_valid || !in_stall) begin
        if (request_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = request_q.pop_front();
          in_valid <= 1'b1;
          kind     <= nxt.kind;
          sample   <= nxt.sample;
          last     <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_lags
    lag_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (lag_expected_q.size() == 0) begin
          $error("correlation: expected none, got %0d", correlation);
          n_errors++;
        end else begin
          e = lag_expected_q.pop_front();
          if (correlation !== e.corr) begin
            $error("correlation: expected %0d, got %0d", e.corr, correlation);
            n_errors++;
          end
          if (final_res !== e.fin) begin
            $error("final_res: expected %0d, got %0d", e.fin, final_res);
            n_errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin : drive_stall
    if (!rst) begin
      // long hold-off so the output register fills and the input backs up
      if (hold_seen != hold_arm) begin
        hold_seen <= hold_arm;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic add_req(logic k, logic signed [SW-1:0] s, logic l);
    req_t r;
    r.kind   = k;
    r.sample = s;
    r.last   = l;
    request_q.push_back(r);
  endtask

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return SW'($urandom_range(0, 65535));
    endcase
  endfunction

  // mostly a reference followed by a signal; some noise and unterminated runs
  task automatic add_burst();
    int  rlen;
    int  slen;
    bit  open_ref;
    bit  open_sig;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4))
        add_req(1'($urandom_range(0, 1)), pick_sample(), 1'($urandom_range(0, 1)));
      return;
    end
    rlen = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
    open_ref = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < rlen; i++)
      add_req(fcc_pkg::KIND_REF, pick_sample(), (i == rlen-1) && !open_ref);
    slen = $urandom_range(1, 10);
    open_sig = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < slen; i++)
      add_req(fcc_pkg::KIND_SIG, pick_sample(), (i == slen-1) && !open_sig);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (request_q.size() != 0 || in_valid || lag_expected_q.size() != 0);
  endtask

  task automatic run_phase(int idle, int stall, int n_items);
    idle_pct  = idle;
    stall_pct = stall;
    while (request_q.size() < n_items) add_burst();
    wait_drained();
  endtask

  initial begin : stimulus
    int rlen;
    // empty reference: no lags, last still clears the delay line
    add_req(fcc_pkg::KIND_SIG, 16'sh7fff, 1'b0);
    add_req(fcc_pkg::KIND_SIG, 16'sh8000, 1'b1);
    add_req(fcc_pkg::KIND_REF, 16'sh8000, 1'b0);
    add_req(fcc_pkg::KIND_REF, 16'sh7fff, 1'b0);
    add_req(fcc_pkg::KIND_REF, 16'shffff, 1'b1);
    add_req(fcc_pkg::KIND_SIG, 16'sh8000, 1'b0);
    add_req(fcc_pkg::KIND_SIG, 16'sh8000, 1'b0);
    add_req(fcc_pkg::KIND_SIG, 16'sh7fff, 1'b1);
    // signal while the reference is still open
    add_req(fcc_pkg::KIND_REF, 16'sh8000, 1'b0);
    add_req(fcc_pkg::KIND_SIG, 16'sh1234, 1'b0);
    add_req(fcc_pkg::KIND_REF, 16'sh7fff, 1'b1);
    add_req(fcc_pkg::KIND_SIG, 16'sh8000, 1'b0);
    // new reference keeps the delay line
    add_req(fcc_pkg::KIND_REF, 16'sh4000, 1'b1);
    add_req(fcc_pkg::KIND_SIG, 16'sh7fff, 1'b1);
    add_req(fcc_pkg::KIND_REF, 16'sh8000, 1'b0);
    add_req(fcc_pkg::KIND_REF, 16'sh8000, 1'b1);
    add_req(fcc_pkg::KIND_SIG, 16'sh8000, 1'b1);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    hold_arm = 1'b1;
    add_req(fcc_pkg::KIND_REF, pick_sample(), 1'b0);
    add_req(fcc_pkg::KIND_REF, pick_sample(), 1'b0);
    add_req(fcc_pkg::KIND_REF, pick_sample(), 1'b1);
    for (int i = 0; i < 12; i++) add_req(fcc_pkg::KIND_SIG, pick_sample(), i == 11);
    wait_drained();

    // overlong reference of extremes, full-length signal: largest sums
    rlen = $urandom_range(33, 36);
    for (int i = 0; i < rlen; i++) add_req(fcc_pkg::KIND_REF, 16'sh8000, i == rlen-1);
    for (int i = 0; i < MAX_LEN; i++)
      add_req(fcc_pkg::KIND_SIG, $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff,
              i == MAX_LEN-1);
    wait_drained();

    run_phase(0, 0, 80);
    run_phase(80, 0, 80);
    run_phase(0, 80, 80);
    run_phase(33, 33, 80);
    idle_pct  = 0;
    stall_pct = 0;

    repeat (100) @(negedge clk);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
